// ===== rtl/kcv2d_pkg.sv =====
// Package for the 2D constant-velocity Kalman track core.
// Holds fixed-point constants, the state memory map and the micro-op program ROM.
// No dependencies.
package kcv2d_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int DATA_W      = 32;
   localparam int ADDR_W      = 6;
   localparam int RAM_DEPTH   = 64;
   localparam int STATE_WORDS = 20;
   localparam int SWEEP_W     = 5;
   localparam int PC_W        = 7;
   localparam int DIV_W       = DATA_W + FRAC_BITS;
   localparam int DCNT_W      = $clog2(DIV_W + 1);

   localparam logic [DATA_W-1:0] ONE_Q   = DATA_W'(1) << FRAC_BITS;
   localparam logic [63:0]       HALF_P  = 64'(1) << (FRAC_BITS - 1);
   localparam logic [DATA_W-1:0] SMALL_Q = DATA_W'(((64'd4 << FRAC_BITS) + 64'd50) / 64'd100);
   localparam logic [DATA_W-1:0] MAX_Q   = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] MIN_Q   = {1'b1, {(DATA_W-1){1'b0}}};

   // operation codes
   localparam logic [1:0] OP_INIT    = 2'd0;
   localparam logic [1:0] OP_PREDICT = 2'd1;
   localparam logic [1:0] OP_UPDATE  = 2'd2;

   // configuration register indexes
   localparam logic CSR_ACCEL_NOISE    = 1'b0;
   localparam logic CSR_POSITION_NOISE = 1'b1;

   // memory map: covariance 0..15 (row major), track vector 16..19, scratch above
   localparam logic [ADDR_W-1:0] A_P0  = 6'd0;
   localparam logic [ADDR_W-1:0] A_P1  = 6'd1;
   localparam logic [ADDR_W-1:0] A_P2  = 6'd2;
   localparam logic [ADDR_W-1:0] A_P4  = 6'd4;
   localparam logic [ADDR_W-1:0] A_P5  = 6'd5;
   localparam logic [ADDR_W-1:0] A_P7  = 6'd7;
   localparam logic [ADDR_W-1:0] A_P8  = 6'd8;
   localparam logic [ADDR_W-1:0] A_P10 = 6'd10;
   localparam logic [ADDR_W-1:0] A_P13 = 6'd13;
   localparam logic [ADDR_W-1:0] A_P15 = 6'd15;
   localparam logic [ADDR_W-1:0] A_TV0 = 6'd16;
   localparam logic [ADDR_W-1:0] A_TV1 = 6'd17;
   localparam logic [ADDR_W-1:0] A_TV2 = 6'd18;
   localparam logic [ADDR_W-1:0] A_TV3 = 6'd19;
   localparam logic [ADDR_W-1:0] A_R   = 6'd20;
   localparam logic [ADDR_W-1:0] A_S00 = 6'd21;
   localparam logic [ADDR_W-1:0] A_S11 = 6'd22;
   localparam logic [ADDR_W-1:0] A_DET = 6'd23;
   localparam logic [ADDR_W-1:0] A_TA  = 6'd24;
   localparam logic [ADDR_W-1:0] A_TB  = 6'd25;
   localparam logic [ADDR_W-1:0] A_K0  = 6'd26;
   localparam logic [ADDR_W-1:0] A_K1  = 6'd27;
   localparam logic [ADDR_W-1:0] A_K2  = 6'd28;
   localparam logic [ADDR_W-1:0] A_K3  = 6'd29;
   localparam logic [ADDR_W-1:0] A_K4  = 6'd30;
   localparam logic [ADDR_W-1:0] A_K5  = 6'd31;
   localparam logic [ADDR_W-1:0] A_K6  = 6'd32;
   localparam logic [ADDR_W-1:0] A_K7  = 6'd33;
   localparam logic [ADDR_W-1:0] A_E0  = 6'd34;
   localparam logic [ADDR_W-1:0] A_E1  = 6'd35;
   localparam logic [ADDR_W-1:0] A_Q   = 6'd36;
   localparam logic [ADDR_W-1:0] A_D2  = 6'd37;
   localparam logic [ADDR_W-1:0] A_D3  = 6'd38;
   localparam logic [ADDR_W-1:0] A_D4  = 6'd39;
   localparam logic [ADDR_W-1:0] A_Q4  = 6'd40;
   localparam logic [ADDR_W-1:0] A_Q3  = 6'd41;
   localparam logic [ADDR_W-1:0] A_Q2  = 6'd42;
   localparam logic [ADDR_W-1:0] A_NONE = 6'd0;

   // program entry points
   localparam logic [PC_W-1:0] PC_PREDICT = 7'd0;
   localparam logic [PC_W-1:0] PC_UPDATE  = 7'd34;

   typedef enum logic [1:0] {UOP_MAC, UOP_DIV, UOP_CHK, UOP_END} uop_kind_type;
   typedef enum logic [2:0] {SRC_RAM, SRC_DT, SRC_ACC, SRC_PNS, SRC_ONE} src_type;
   typedef enum logic [1:0] {ADD_RAM, ADD_ZERO, ADD_MX, ADD_MY} add_type;

   // one micro-op: dst = sat(c +/- (fmul(a, b) >>> shift)), or a divide / check
   typedef struct packed {
      uop_kind_type      kind;
      src_type           a_src;
      logic [ADDR_W-1:0] a_addr;
      src_type           b_src;
      logic [ADDR_W-1:0] b_addr;
      add_type           c_src;
      logic [ADDR_W-1:0] c_addr;
      logic              neg;
      logic [1:0]        shift;
      logic [ADDR_W-1:0] dst;
   } uop_type;

   function automatic logic [ADDR_W-1:0] pa(logic [1:0] r, logic [1:0] c);
      return {{(ADDR_W-4){1'b0}}, r, c};
   endfunction

   function automatic uop_type mac(src_type as, logic [ADDR_W-1:0] aa, src_type bs,
                                   logic [ADDR_W-1:0] ba, add_type cs,
                                   logic [ADDR_W-1:0] ca, logic n, logic [1:0] sh,
                                   logic [ADDR_W-1:0] d);
      uop_type u;
      u.kind = UOP_MAC;  u.a_src = as; u.a_addr = aa; u.b_src = bs; u.b_addr = ba;
      u.c_src = cs;      u.c_addr = ca; u.neg = n;    u.shift = sh; u.dst = d;
      return u;
   endfunction

   function automatic uop_type ctl(uop_kind_type k, logic [ADDR_W-1:0] aa,
                                   logic [ADDR_W-1:0] ba, logic [ADDR_W-1:0] d);
      uop_type u;
      u.kind = k;        u.a_src = SRC_RAM; u.a_addr = aa; u.b_src = SRC_RAM;
      u.b_addr = ba;     u.c_src = ADD_ZERO; u.c_addr = A_NONE; u.neg = 1'b0;
      u.shift = 2'd0;    u.dst = d;
      return u;
   endfunction

   // program ROM: predict at PC_PREDICT, update at PC_UPDATE
   function automatic uop_type uop_at(logic [PC_W-1:0] pc);
      uop_type          u;
      logic [PC_W-1:0]  off;
      logic [1:0]       i;
      logic [1:0]       j;
      logic             h;
      logic [2:0]       s;
      u = ctl(UOP_END, A_NONE, A_NONE, A_NONE);
      off = '0; i = '0; j = '0; h = 1'b0; s = '0;
      if (pc < 7'd8) begin
         // rows 0,1 gain dt times rows 2,3
         u = mac(SRC_DT, A_NONE, SRC_RAM, pa({1'b1, pc[0]}, pc[2:1]), ADD_RAM,
                 pa({1'b0, pc[0]}, pc[2:1]), 1'b0, 2'd0, pa({1'b0, pc[0]}, pc[2:1]));
      end else if (pc < 7'd16) begin
         // columns 0,1 gain dt times columns 2,3
         off = pc - 7'd8;
         i = off[2:1];
         h = off[0];
         u = mac(SRC_RAM, pa(i, {1'b1, h}), SRC_DT, A_NONE, ADD_RAM, pa(i, {1'b0, h}),
                 1'b0, 2'd0, pa(i, {1'b0, h}));
      end else if (pc < 7'd34) begin
         case (pc)
            7'd16: u = mac(SRC_ACC, A_NONE, SRC_ACC, A_NONE, ADD_ZERO, A_NONE, 1'b0, 2'd0, A_Q);
            7'd17: u = mac(SRC_DT, A_NONE, SRC_DT, A_NONE, ADD_ZERO, A_NONE, 1'b0, 2'd0, A_D2);
            7'd18: u = mac(SRC_RAM, A_D2, SRC_DT, A_NONE, ADD_ZERO, A_NONE, 1'b0, 2'd0, A_D3);
            7'd19: u = mac(SRC_RAM, A_D2, SRC_RAM, A_D2, ADD_ZERO, A_NONE, 1'b0, 2'd0, A_D4);
            7'd20: u = mac(SRC_RAM, A_Q, SRC_RAM, A_D4, ADD_ZERO, A_NONE, 1'b0, 2'd2, A_Q4);
            7'd21: u = mac(SRC_RAM, A_Q, SRC_RAM, A_D3, ADD_ZERO, A_NONE, 1'b0, 2'd1, A_Q3);
            7'd22: u = mac(SRC_RAM, A_Q, SRC_RAM, A_D2, ADD_ZERO, A_NONE, 1'b0, 2'd0, A_Q2);
            7'd23: u = mac(SRC_RAM, A_Q4, SRC_ONE, A_NONE, ADD_RAM, A_P0, 1'b0, 2'd0, A_P0);
            7'd24: u = mac(SRC_RAM, A_Q4, SRC_ONE, A_NONE, ADD_RAM, A_P5, 1'b0, 2'd0, A_P5);
            7'd25: u = mac(SRC_RAM, A_Q3, SRC_ONE, A_NONE, ADD_RAM, A_P2, 1'b0, 2'd0, A_P2);
            7'd26: u = mac(SRC_RAM, A_Q3, SRC_ONE, A_NONE, ADD_RAM, A_P8, 1'b0, 2'd0, A_P8);
            7'd27: u = mac(SRC_RAM, A_Q3, SRC_ONE, A_NONE, ADD_RAM, A_P7, 1'b0, 2'd0, A_P7);
            7'd28: u = mac(SRC_RAM, A_Q3, SRC_ONE, A_NONE, ADD_RAM, A_P13, 1'b0, 2'd0, A_P13);
            7'd29: u = mac(SRC_RAM, A_Q2, SRC_ONE, A_NONE, ADD_RAM, A_P10, 1'b0, 2'd0, A_P10);
            7'd30: u = mac(SRC_RAM, A_Q2, SRC_ONE, A_NONE, ADD_RAM, A_P15, 1'b0, 2'd0, A_P15);
            7'd31: u = mac(SRC_DT, A_NONE, SRC_RAM, A_TV2, ADD_RAM, A_TV0, 1'b0, 2'd0, A_TV0);
            7'd32: u = mac(SRC_DT, A_NONE, SRC_RAM, A_TV3, ADD_RAM, A_TV1, 1'b0, 2'd0, A_TV1);
            default: u = ctl(UOP_END, A_NONE, A_NONE, A_NONE);
         endcase
      end else if (pc < 7'd40) begin
         case (pc)
            7'd34: u = mac(SRC_PNS, A_NONE, SRC_PNS, A_NONE, ADD_ZERO, A_NONE, 1'b0, 2'd0, A_R);
            7'd35: u = mac(SRC_RAM, A_P0, SRC_ONE, A_NONE, ADD_RAM, A_R, 1'b0, 2'd0, A_S00);
            7'd36: u = mac(SRC_RAM, A_P5, SRC_ONE, A_NONE, ADD_RAM, A_R, 1'b0, 2'd0, A_S11);
            7'd37: u = mac(SRC_RAM, A_S00, SRC_RAM, A_S11, ADD_ZERO, A_NONE, 1'b0, 2'd0, A_TA);
            7'd38: u = mac(SRC_RAM, A_P1, SRC_RAM, A_P4, ADD_RAM, A_TA, 1'b1, 2'd0, A_DET);
            default: u = ctl(UOP_CHK, A_DET, A_NONE, A_NONE);
         endcase
      end else if (pc < 7'd64) begin
         // gains, built in place in the gain slots
         off = pc - 7'd40;
         i = off[1:0];
         s = off[4:2];
         case (s)
            3'd0: u = mac(SRC_RAM, pa(i, 2'd0), SRC_RAM, A_S11, ADD_ZERO, A_NONE, 1'b0, 2'd0,
                          A_K0 + ADDR_W'({i, 1'b0}));
            3'd1: u = mac(SRC_RAM, pa(i, 2'd1), SRC_RAM, A_P4, ADD_RAM,
                          A_K0 + ADDR_W'({i, 1'b0}), 1'b1, 2'd0, A_K0 + ADDR_W'({i, 1'b0}));
            3'd2: u = ctl(UOP_DIV, A_K0 + ADDR_W'({i, 1'b0}), A_DET,
                          A_K0 + ADDR_W'({i, 1'b0}));
            3'd3: u = mac(SRC_RAM, pa(i, 2'd1), SRC_RAM, A_S00, ADD_ZERO, A_NONE, 1'b0, 2'd0,
                          A_K0 + ADDR_W'({i, 1'b1}));
            3'd4: u = mac(SRC_RAM, pa(i, 2'd0), SRC_RAM, A_P1, ADD_RAM,
                          A_K0 + ADDR_W'({i, 1'b1}), 1'b1, 2'd0, A_K0 + ADDR_W'({i, 1'b1}));
            default: u = ctl(UOP_DIV, A_K0 + ADDR_W'({i, 1'b1}), A_DET,
                             A_K0 + ADDR_W'({i, 1'b1}));
         endcase
      end else if (pc < 7'd66) begin
         // innovation
         if (pc[0]) begin
            u = mac(SRC_RAM, A_TV1, SRC_ONE, A_NONE, ADD_MY, A_NONE, 1'b1, 2'd0, A_E1);
         end else begin
            u = mac(SRC_RAM, A_TV0, SRC_ONE, A_NONE, ADD_MX, A_NONE, 1'b1, 2'd0, A_E0);
         end
      end else if (pc < 7'd74) begin
         // state correction
         off = pc - 7'd66;
         i = off[2:1];
         h = off[0];
         u = mac(SRC_RAM, A_K0 + ADDR_W'({i, h}), SRC_RAM, A_E0 + ADDR_W'(h), ADD_RAM,
                 A_TV0 + ADDR_W'(i), 1'b0, 2'd0, A_TV0 + ADDR_W'(i));
      end else if (pc < 7'd106) begin
         // covariance correction, column by column; rows 0,1 go through scratch
         off = pc - 7'd74;
         j = off[4:3];
         s = off[2:0];
         case (s)
            3'd0: u = mac(SRC_RAM, A_K4, SRC_RAM, pa(2'd0, j), ADD_RAM, pa(2'd2, j), 1'b1,
                          2'd0, pa(2'd2, j));
            3'd1: u = mac(SRC_RAM, A_K5, SRC_RAM, pa(2'd1, j), ADD_RAM, pa(2'd2, j), 1'b1,
                          2'd0, pa(2'd2, j));
            3'd2: u = mac(SRC_RAM, A_K6, SRC_RAM, pa(2'd0, j), ADD_RAM, pa(2'd3, j), 1'b1,
                          2'd0, pa(2'd3, j));
            3'd3: u = mac(SRC_RAM, A_K7, SRC_RAM, pa(2'd1, j), ADD_RAM, pa(2'd3, j), 1'b1,
                          2'd0, pa(2'd3, j));
            3'd4: u = mac(SRC_RAM, A_K0, SRC_RAM, pa(2'd0, j), ADD_RAM, pa(2'd0, j), 1'b1,
                          2'd0, A_TA);
            3'd5: u = mac(SRC_RAM, A_K2, SRC_RAM, pa(2'd0, j), ADD_RAM, pa(2'd1, j), 1'b1,
                          2'd0, A_TB);
            3'd6: u = mac(SRC_RAM, A_K1, SRC_RAM, pa(2'd1, j), ADD_RAM, A_TA, 1'b1,
                          2'd0, pa(2'd0, j));
            default: u = mac(SRC_RAM, A_K3, SRC_RAM, pa(2'd1, j), ADD_RAM, A_TB, 1'b1,
                             2'd0, pa(2'd1, j));
         endcase
      end
      return u;
   endfunction

endpackage

// ===== rtl/kcv2d_ram.sv =====
// Generic synchronous RAM: one write port, two registered read ports.
// No dependencies.
module kcv2d_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] ra_addr,
   output logic [WIDTH-1:0]         ra_data,
   input  logic [$clog2(DEPTH)-1:0] rb_addr,
   output logic [WIDTH-1:0]         rb_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      ra_data <= mem_ff[ra_addr];
      rb_data <= mem_ff[rb_addr];
   end

endmodule

// ===== rtl/kalman_cv2d_filter_step_core.sv =====
// Kalman CV2D track core on kcv2d_pkg and kcv2d_ram; one shared 32x32 multiplier
// and a 1-bit-per-cycle divider, one transaction at a time.
// A zero-step predict or an unknown op goes straight to read-out; an update runs eight
// divides, and a singular update stops at its check. req_tready rises with rsp_tvalid.
// Reset: synchronous, active high; a clearing pass over the 20 state words writes a zero
// track and an identity covariance before req_tready rises.
module kalman_cv2d_filter_step_core
   import kcv2d_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   // input channel
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [87:0]  req_tdata,   // time_step[19:0], meas_x[51:20], meas_y[83:52]
   input  logic [1:0]   req_tuser,   // operation[1:0]
   // result channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [191:0] rsp_tdata,   // est_x, est_y, est_vx, est_vy (32), var_x, var_y (31)
   // configuration
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [24:0]  csr_wdata
);

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_INIT, ST_ISSUE, ST_ISSC, ST_RND, ST_ACC,
      ST_DLOAD, ST_DITER, ST_DFIN, ST_CHKW, ST_OUTW, ST_OUT0, ST_OUT1, ST_OUT2, ST_OUT3
   } state_type;

   state_type              state_ff, state_in;
   logic [PC_W-1:0]        pc_ff, pc_in;
   logic [SWEEP_W-1:0]     sweep_ff, sweep_in;
   logic [1:0]             op_ff, op_in;
   logic [19:0]            dt_ff, dt_in;
   logic [DATA_W-1:0]      mx_ff, mx_in, my_ff, my_in;
   logic [24:0]            accn_ff, accn_in;
   logic [20:0]            posn_ff, posn_in;
   logic signed [63:0]     prod_ff, prod_in;
   logic [DATA_W-1:0]      m_ff, m_in, c_ff, c_in;
   logic [DIV_W-1:0]       dnum_ff, dnum_in, dquo_ff, dquo_in;
   logic [DATA_W:0]        drem_ff, drem_in;
   logic [DATA_W-1:0]      dden_ff, dden_in;
   logic                   dneg_ff, dneg_in;
   logic [DCNT_W-1:0]      dcnt_ff, dcnt_in;
   logic [DATA_W-1:0]      ox_ff, ox_in, oy_ff, oy_in, ovx_ff, ovx_in, ovy_ff, ovy_in;
   logic [30:0]            ovarx_ff, ovarx_in, ovary_ff, ovary_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // memory ports
   logic                   ram_we;
   logic [ADDR_W-1:0]      ram_waddr, ram_ra, ram_rb;
   logic [DATA_W-1:0]      ram_wdata, ram_a_q, ram_b_q;

   // datapath
   uop_type                uop;
   logic [DATA_W-1:0]      a_opnd, b_opnd;
   logic signed [63:0]     rnd, rsh;
   logic [DATA_W-1:0]      rsat, msh;
   logic signed [33:0]     asum;
   logic [DATA_W-1:0]      asat;
   logic [DATA_W:0]        rem_sh;
   logic                   qbit;
   logic [DATA_W-1:0]      dres, abs_a, abs_b;
   logic [DATA_W-1:0]      sweep_val;
   logic [ADDR_W-1:0]      sweep_addr;
   logic                   req_take;

   kcv2d_ram #(.WIDTH(DATA_W), .DEPTH(RAM_DEPTH)) u_state_ram (
      .clock   (clock),
      .we      (ram_we),
      .waddr   (ram_waddr),
      .wdata   (ram_wdata),
      .ra_addr (ram_ra),
      .ra_data (ram_a_q),
      .rb_addr (ram_rb),
      .rb_data (ram_b_q)
   );

   assign uop        = uop_at(pc_ff);
   assign req_tready = (state_ff == ST_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, ovary_ff, ovarx_ff, ovy_ff, ovx_ff, oy_ff, ox_ff};
   assign sweep_addr = ADDR_W'(sweep_ff);

   // operand select for the multiplier
   always_comb begin
      case (uop.a_src)
         SRC_DT:  a_opnd = DATA_W'(dt_ff);
         SRC_ACC: a_opnd = DATA_W'(accn_ff);
         SRC_PNS: a_opnd = DATA_W'(posn_ff);
         SRC_ONE: a_opnd = ONE_Q;
         default: a_opnd = ram_a_q;
      endcase
      case (uop.b_src)
         SRC_DT:  b_opnd = DATA_W'(dt_ff);
         SRC_ACC: b_opnd = DATA_W'(accn_ff);
         SRC_PNS: b_opnd = DATA_W'(posn_ff);
         SRC_ONE: b_opnd = ONE_Q;
         default: b_opnd = ram_b_q;
      endcase
   end

   // product rounding and saturation
   always_comb begin
      rnd = prod_ff + $signed(HALF_P);
      rsh = rnd >>> FRAC_BITS;
      if (!rsh[63] && (|rsh[62:DATA_W-1])) begin
         rsat = MAX_Q;
      end else if (rsh[63] && !(&rsh[62:DATA_W-1])) begin
         rsat = MIN_Q;
      end else begin
         rsat = rsh[DATA_W-1:0];
      end
      msh = DATA_W'($signed(rsat) >>> uop.shift);
   end

   // saturating accumulate
   always_comb begin
      if (uop.neg) begin
         asum = {{2{c_ff[DATA_W-1]}}, c_ff} - {{2{m_ff[DATA_W-1]}}, m_ff};
      end else begin
         asum = {{2{c_ff[DATA_W-1]}}, c_ff} + {{2{m_ff[DATA_W-1]}}, m_ff};
      end
      if (!asum[33] && (|asum[32:DATA_W-1])) begin
         asat = MAX_Q;
      end else if (asum[33] && !(&asum[32:DATA_W-1])) begin
         asat = MIN_Q;
      end else begin
         asat = asum[DATA_W-1:0];
      end
   end

   // divider step and final sign / saturation
   always_comb begin
      rem_sh = {drem_ff[DATA_W-1:0], dnum_ff[DIV_W-1]};
      qbit   = (rem_sh >= {1'b0, dden_ff});
      abs_a  = ram_a_q[DATA_W-1] ? (~ram_a_q + DATA_W'(1)) : ram_a_q;
      abs_b  = ram_b_q[DATA_W-1] ? (~ram_b_q + DATA_W'(1)) : ram_b_q;
      if (dneg_ff) begin
         if (dquo_ff > DIV_W'(MIN_Q)) begin
            dres = MIN_Q;
         end else begin
            dres = ~dquo_ff[DATA_W-1:0] + DATA_W'(1);
         end
      end else begin
         if (dquo_ff > DIV_W'(MAX_Q)) begin
            dres = MAX_Q;
         end else begin
            dres = dquo_ff[DATA_W-1:0];
         end
      end
   end

   // values written by the clearing pass and by init
   always_comb begin
      sweep_val = '0;
      if (sweep_addr < A_TV0) begin
         if (state_ff == ST_CLEAR) begin
            if (sweep_addr == A_P0 || sweep_addr == A_P5 || sweep_addr == A_P10 ||
                sweep_addr == A_P15) begin
               sweep_val = ONE_Q;
            end
         end else if (sweep_addr == A_P0 || sweep_addr == A_P5) begin
            sweep_val = SMALL_Q;
         end else if (sweep_addr == A_P10 || sweep_addr == A_P15) begin
            sweep_val = ONE_Q;
         end
      end else if (state_ff == ST_INIT) begin
         if (sweep_addr == A_TV0) begin
            sweep_val = mx_ff;
         end else if (sweep_addr == A_TV1) begin
            sweep_val = my_ff;
         end
      end
   end

   // sequencer next state and memory port control
   always_comb begin
      state_in = state_ff;   pc_in = pc_ff;       sweep_in = sweep_ff;
      op_in = op_ff;         dt_in = dt_ff;       mx_in = mx_ff;       my_in = my_ff;
      accn_in = accn_ff;     posn_in = posn_ff;   prod_in = prod_ff;
      m_in = m_ff;           c_in = c_ff;
      dnum_in = dnum_ff;     dquo_in = dquo_ff;   drem_in = drem_ff;   dden_in = dden_ff;
      dneg_in = dneg_ff;     dcnt_in = dcnt_ff;
      ox_in = ox_ff;         oy_in = oy_ff;       ovx_in = ovx_ff;     ovy_in = ovy_ff;
      ovarx_in = ovarx_ff;   ovary_in = ovary_ff; rsp_valid_in = rsp_valid_ff;
      ram_we = 1'b0;         ram_waddr = uop.dst; ram_wdata = asat;
      ram_ra = A_NONE;       ram_rb = A_NONE;

      // configuration writes
      if (csr_we) begin
         if (csr_index == CSR_ACCEL_NOISE) begin
            accn_in = csr_wdata;
         end else begin
            posn_in = csr_wdata[20:0];
         end
      end

      // result transaction completes
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR, ST_INIT: begin
            ram_we    = 1'b1;
            ram_waddr = sweep_addr;
            ram_wdata = sweep_val;
            sweep_in  = sweep_ff + SWEEP_W'(1);
            if (sweep_ff == SWEEP_W'(STATE_WORDS - 1)) begin
               sweep_in = '0;
               state_in = (state_ff == ST_CLEAR) ? ST_IDLE : ST_OUTW;
            end
         end
         ST_IDLE: begin
            if (req_take) begin
               op_in = req_tuser;
               dt_in = req_tdata[19:0];
               mx_in = req_tdata[51:20];
               my_in = req_tdata[83:52];
               sweep_in = '0;
               case (req_tuser)
                  OP_INIT: state_in = ST_INIT;
                  OP_PREDICT: begin
                     pc_in    = PC_PREDICT;
                     state_in = (req_tdata[19:0] == 20'd0) ? ST_OUTW : ST_ISSUE;
                  end
                  OP_UPDATE: begin
                     pc_in    = PC_UPDATE;
                     state_in = ST_ISSUE;
                  end
                  default: state_in = ST_OUTW;
               endcase
            end
         end
         ST_ISSUE: begin
            ram_ra = uop.a_addr;
            ram_rb = uop.b_addr;
            case (uop.kind)
               UOP_MAC: state_in = ST_ISSC;
               UOP_DIV: state_in = ST_DLOAD;
               UOP_CHK: state_in = ST_CHKW;
               default: state_in = ST_OUTW;
            endcase
         end
         ST_ISSC: begin
            ram_ra   = uop.c_addr;
            prod_in  = $signed(a_opnd) * $signed(b_opnd);
            state_in = ST_RND;
         end
         ST_RND: begin
            m_in = msh;
            case (uop.c_src)
               ADD_ZERO: c_in = '0;
               ADD_MX:   c_in = mx_ff;
               ADD_MY:   c_in = my_ff;
               default:  c_in = ram_a_q;
            endcase
            state_in = ST_ACC;
         end
         ST_ACC: begin
            ram_we   = 1'b1;
            pc_in    = pc_ff + PC_W'(1);
            state_in = ST_ISSUE;
         end
         ST_DLOAD: begin
            dneg_in  = ram_a_q[DATA_W-1] ^ ram_b_q[DATA_W-1];
            dnum_in  = {abs_a, {FRAC_BITS{1'b0}}};
            dden_in  = abs_b;
            drem_in  = '0;
            dquo_in  = '0;
            dcnt_in  = '0;
            state_in = ST_DITER;
         end
         ST_DITER: begin
            drem_in = qbit ? (rem_sh - {1'b0, dden_ff}) : rem_sh;
            dnum_in = {dnum_ff[DIV_W-2:0], 1'b0};
            dquo_in = {dquo_ff[DIV_W-2:0], qbit};
            dcnt_in = dcnt_ff + DCNT_W'(1);
            if (dcnt_ff == DCNT_W'(DIV_W - 1)) begin
               state_in = ST_DFIN;
            end
         end
         ST_DFIN: begin
            ram_we    = 1'b1;
            ram_wdata = dres;
            pc_in     = pc_ff + PC_W'(1);
            state_in  = ST_ISSUE;
         end
         ST_CHKW: begin
            // singular innovation leaves the track as it is
            if (ram_a_q == '0) begin
               state_in = ST_OUTW;
            end else begin
               pc_in    = pc_ff + PC_W'(1);
               state_in = ST_ISSUE;
            end
         end
         ST_OUTW: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = ST_OUT0;
            end
         end
         ST_OUT0: begin
            ram_ra   = A_TV0;
            ram_rb   = A_TV1;
            state_in = ST_OUT1;
         end
         ST_OUT1: begin
            ram_ra   = A_TV2;
            ram_rb   = A_TV3;
            ox_in    = ram_a_q;
            oy_in    = ram_b_q;
            state_in = ST_OUT2;
         end
         ST_OUT2: begin
            ram_ra   = A_P0;
            ram_rb   = A_P5;
            ovx_in   = ram_a_q;
            ovy_in   = ram_b_q;
            state_in = ST_OUT3;
         end
         ST_OUT3: begin
            ovarx_in     = ram_a_q[DATA_W-1] ? 31'd0 : ram_a_q[30:0];
            ovary_in     = ram_b_q[DATA_W-1] ? 31'd0 : ram_b_q[30:0];
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         pc_ff        <= '0;
         sweep_ff     <= '0;
         dcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         accn_ff      <= 25'd196608;
         posn_ff      <= 21'd7864;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         sweep_ff     <= sweep_in;
         dcnt_ff      <= dcnt_in;
         rsp_valid_ff <= rsp_valid_in;
         accn_ff      <= accn_in;
         posn_ff      <= posn_in;
      end
      op_ff    <= op_in;     dt_ff    <= dt_in;     mx_ff  <= mx_in;   my_ff  <= my_in;
      prod_ff  <= prod_in;   m_ff     <= m_in;      c_ff   <= c_in;
      dnum_ff  <= dnum_in;   dquo_ff  <= dquo_in;   drem_ff <= drem_in;
      dden_ff  <= dden_in;   dneg_ff  <= dneg_in;
      ox_ff    <= ox_in;     oy_ff    <= oy_in;     ovx_ff <= ovx_in;  ovy_ff <= ovy_in;
      ovarx_ff <= ovarx_in;  ovary_ff <= ovary_in;
   end

`ifndef NO_ASSERTIONS
   // a new result only appears at the end of the read-out sequence
   a_rsp_from_readout: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_OUT3)
      else $error("result raised outside read-out");

   // the state memory is only written by the sweep, an accumulate or a divide
   a_write_states: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_ACC || state_ff == ST_DFIN || state_ff == ST_INIT ||
                  state_ff == ST_CLEAR))
      else $error("unexpected state memory write");

   // divider never runs past its width
   a_div_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DITER |-> dcnt_ff < DCNT_W'(DIV_W))
      else $error("divider count overrun");

   // read-out never starts over a result still waiting
   a_readout_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT0 |-> !rsp_valid_ff)
      else $error("read-out would overwrite pending result");
`endif

endmodule
